>>> hw/rtl/rq2p_pkg.sv
// Shared types, register indexes and matrix coefficients for the RGB quad to P010 converter.
// Holds the 8-to-10-bit channel expansion used by the luma lanes and the chroma merge stage.
// No dependencies.
`default_nettype none

package rq2p_pkg;

    // Number of pixels in one quad, one luma lane each.
    localparam int LANES = 4;

    // Configuration register indexes.
    localparam logic CFG_BGRA_ORDER = 1'b0;
    localparam logic CFG_USE_BT2020 = 1'b1;

    // Rounding bias for the Q16 products.
    localparam int ROUND_BIAS = 32768;

    // Offset added to chroma and the clamp limit of a 10-bit sample.
    localparam int CHROMA_OFFSET = 512;
    localparam int MAX10 = 1023;

    // Luma coefficients, Q16, all positive.
    localparam logic [15:0] Y709_R  = 16'd13933;
    localparam logic [15:0] Y709_G  = 16'd46871;
    localparam logic [15:0] Y709_B  = 16'd4732;
    localparam logic [15:0] Y2020_R = 16'd17218;
    localparam logic [15:0] Y2020_G = 16'd44444;
    localparam logic [15:0] Y2020_B = 16'd3886;

    // Chroma coefficients, Q16, signed.
    localparam logic signed [17:0] CB709_R  = -18'sd7508;
    localparam logic signed [17:0] CB709_G  = -18'sd25259;
    localparam logic signed [17:0] CB709_B  = 18'sd32768;
    localparam logic signed [17:0] CR709_R  = 18'sd32768;
    localparam logic signed [17:0] CR709_G  = -18'sd29763;
    localparam logic signed [17:0] CR709_B  = -18'sd3005;
    localparam logic signed [17:0] CB2020_R = -18'sd9147;
    localparam logic signed [17:0] CB2020_G = -18'sd23621;
    localparam logic signed [17:0] CB2020_B = 18'sd32768;
    localparam logic signed [17:0] CR2020_R = 18'sd32768;
    localparam logic signed [17:0] CR2020_G = -18'sd30134;
    localparam logic signed [17:0] CR2020_B = -18'sd2634;

    // One input transaction: a 2x2 pixel quad.
    typedef struct packed {
        logic [31:0] pixel_top_left;
        logic [31:0] pixel_top_right;
        logic [31:0] pixel_bottom_left;
        logic [31:0] pixel_bottom_right;
    } quad_t;

    // One output transaction: four luma words and one chroma pair.
    typedef struct packed {
        logic [15:0] luma_top_left;
        logic [15:0] luma_top_right;
        logic [15:0] luma_bottom_left;
        logic [15:0] luma_bottom_right;
        logic [15:0] cb_word;
        logic [15:0] cr_word;
    } result_t;

    // Channels of one pixel at 8 and 10 bits.
    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb8_t;

    typedef struct packed {
        logic [9:0] r;
        logic [9:0] g;
        logic [9:0] b;
    } rgb10_t;

    // Expands an 8-bit value to 10 bits as round(v * 1023 / 255).
    // This equals 4v plus the number of thresholds 43, 128 and 213 that v reaches.
    function automatic logic [9:0] widen10(input logic [7:0] v);
        logic [1:0] adj;
        adj = {1'b0, v >= 8'd43} + {1'b0, v >= 8'd128} + {1'b0, v >= 8'd213};
        return {v, 2'b00} + {8'b0, adj};
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/rq2p_lane.sv
// Luma lane: splits one pixel into channels, expands them and computes one P010 luma word.
// Three register stages: expansion, products, rounding and clamp. Depends on rq2p_pkg.
`default_nettype none

module rq2p_lane
    import rq2p_pkg::*;
(
    input  wire logic        clk,
    input  wire logic [31:0] pixel,
    input  wire logic        bgra_order,
    input  wire logic        use_bt2020,
    output rgb8_t            chan,
    output logic [15:0]      luma
);

    rgb10_t      wide_reg, wide_next;
    logic [15:0] coef_r, coef_g, coef_b;
    logic [25:0] prod_r_reg, prod_g_reg, prod_b_reg;
    logic [25:0] prod_r_next, prod_g_next, prod_b_next;
    logic [27:0] sum;
    logic [11:0] y12;
    logic [15:0] luma_reg, luma_next;

    // Byte order selection; the unused byte is dropped.
    always_comb
    begin
        if (bgra_order)
        begin
            chan.r = pixel[23:16];
            chan.g = pixel[15:8];
            chan.b = pixel[7:0];
        end
        else
        begin
            chan.r = pixel[15:8];
            chan.g = pixel[23:16];
            chan.b = pixel[31:24];
        end
    end

    // Stage 1: expand each channel to 10 bits.
    always_comb
    begin
        wide_next.r = widen10(chan.r);
        wide_next.g = widen10(chan.g);
        wide_next.b = widen10(chan.b);
    end

    // Stage 2: one product per channel with the selected matrix row.
    always_comb
    begin
        coef_r      = use_bt2020 ? Y2020_R : Y709_R;
        coef_g      = use_bt2020 ? Y2020_G : Y709_G;
        coef_b      = use_bt2020 ? Y2020_B : Y709_B;
        prod_r_next = coef_r * wide_reg.r;
        prod_g_next = coef_g * wide_reg.g;
        prod_b_next = coef_b * wide_reg.b;
    end

    // Stage 3: sum, round, clamp to full scale and pack as P010.
    always_comb
    begin
        sum = 28'(prod_r_reg) + 28'(prod_g_reg) + 28'(prod_b_reg) + 28'(ROUND_BIAS);
        y12 = sum[27:16];
        if (y12 > 12'(MAX10))
        begin
            luma_next = {10'(MAX10), 6'b0};
        end
        else
        begin
            luma_next = {y12[9:0], 6'b0};
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge clk)
    begin
        wide_reg   <= wide_next;
        prod_r_reg <= prod_r_next;
        prod_g_reg <= prod_g_next;
        prod_b_reg <= prod_b_next;
        luma_reg   <= luma_next;
    end

    assign luma = luma_reg;

endmodule

`default_nettype wire

>>> hw/rtl/rq2p_chroma.sv
// Chroma merge stage: averages the channels the four lanes split out and computes Cb and Cr.
// Three register stages, aligned with the luma lanes. Depends on rq2p_pkg.
`default_nettype none

module rq2p_chroma
    import rq2p_pkg::*;
(
    input  wire logic              clk,
    input  wire rgb8_t [LANES-1:0] chans,
    input  wire logic              use_bt2020,
    output logic [15:0]            cb_word,
    output logic [15:0]            cr_word
);

    logic [9:0]  sum_r, sum_g, sum_b;
    rgb10_t      avg_reg, avg_next;
    logic signed [17:0] cb_r, cb_g, cb_b, cr_r, cr_g, cr_b;
    logic signed [28:0] pcb_r_reg, pcb_g_reg, pcb_b_reg;
    logic signed [28:0] pcr_r_reg, pcr_g_reg, pcr_b_reg;
    logic signed [28:0] pcb_r_next, pcb_g_next, pcb_b_next;
    logic signed [28:0] pcr_r_next, pcr_g_next, pcr_b_next;
    logic signed [30:0] cb_sum, cr_sum;
    logic signed [14:0] cb_val, cr_val;
    logic [15:0] cb_reg, cb_next, cr_reg, cr_next;

    // Clamps a signed chroma value to 0..1023 and packs it as P010.
    function automatic logic [15:0] pack10(input logic signed [14:0] v);
        logic [15:0] w;
        if (v < 15'sd0)
        begin
            w = 16'd0;
        end
        else if (v > 15'(MAX10))
        begin
            w = {10'(MAX10), 6'b0};
        end
        else
        begin
            w = {v[9:0], 6'b0};
        end
        return w;
    endfunction

    // Stage 1: rounded average over the quad, then expansion.
    always_comb
    begin
        sum_r = 10'd2;
        sum_g = 10'd2;
        sum_b = 10'd2;
        for (int i = 0; i < LANES; i++)
        begin
            sum_r = sum_r + 10'(chans[i].r);
            sum_g = sum_g + 10'(chans[i].g);
            sum_b = sum_b + 10'(chans[i].b);
        end
        avg_next.r = widen10(sum_r[9:2]);
        avg_next.g = widen10(sum_g[9:2]);
        avg_next.b = widen10(sum_b[9:2]);
    end

    // Stage 2: signed products for both chroma rows.
    always_comb
    begin
        cb_r = use_bt2020 ? CB2020_R : CB709_R;
        cb_g = use_bt2020 ? CB2020_G : CB709_G;
        cb_b = use_bt2020 ? CB2020_B : CB709_B;
        cr_r = use_bt2020 ? CR2020_R : CR709_R;
        cr_g = use_bt2020 ? CR2020_G : CR709_G;
        cr_b = use_bt2020 ? CR2020_B : CR709_B;
        pcb_r_next = cb_r * $signed({1'b0, avg_reg.r});
        pcb_g_next = cb_g * $signed({1'b0, avg_reg.g});
        pcb_b_next = cb_b * $signed({1'b0, avg_reg.b});
        pcr_r_next = cr_r * $signed({1'b0, avg_reg.r});
        pcr_g_next = cr_g * $signed({1'b0, avg_reg.g});
        pcr_b_next = cr_b * $signed({1'b0, avg_reg.b});
    end

    // Stage 3: sum, round toward minus infinity after the bias, offset and clamp.
    always_comb
    begin
        cb_sum  = 31'(pcb_r_reg) + 31'(pcb_g_reg) + 31'(pcb_b_reg) + 31'sd32768;
        cr_sum  = 31'(pcr_r_reg) + 31'(pcr_g_reg) + 31'(pcr_b_reg) + 31'sd32768;
        cb_val  = $signed(cb_sum[30:16]) + 15'(CHROMA_OFFSET);
        cr_val  = $signed(cr_sum[30:16]) + 15'(CHROMA_OFFSET);
        cb_next = pack10(cb_val);
        cr_next = pack10(cr_val);
    end

    // Datapath registers need no reset.
    always_ff @(posedge clk)
    begin
        avg_reg   <= avg_next;
        pcb_r_reg <= pcb_r_next;
        pcb_g_reg <= pcb_g_next;
        pcb_b_reg <= pcb_b_next;
        pcr_r_reg <= pcr_r_next;
        pcr_g_reg <= pcr_g_next;
        pcr_b_reg <= pcr_b_next;
        cb_reg    <= cb_next;
        cr_reg    <= cr_next;
    end

    assign cb_word = cb_reg;
    assign cr_word = cr_reg;

endmodule

`default_nettype wire

>>> hw/rtl/rgb_quad_to_p010_yuv420.sv
// Top level of the RGB quad to P010 4:2:0 converter: input register, four luma lanes,
// chroma merge stage, valid pipeline and configuration registers.
// Depends on rq2p_pkg, rq2p_lane and rq2p_chroma.
//
// Usage:
//   A transaction is accepted at a rising edge with start high and busy low. busy is
//   always low, so a new 2x2 quad may be issued on every clock: one quad per cycle.
//   quad carries the four 32-bit pixels; result carries four luma words and one Cb/Cr
//   pair as P010 words. done marks the single cycle in which result is valid.
//   done follows a quad through the input register and the three register stages
//   (expansion, products, round and clamp) that every lane and the chroma stage
//   each have.
//   The receiver cannot stall; each result appears exactly once and must be taken then.
//   Configuration: cfg_we with cfg_index 0 writes the byte order (1 = BGRA), index 1
//   selects BT.2020 (1) or BT.709 (0). Write only while no transaction is in flight.
//   Reset clears both configuration bits and the valid pipeline; no result follows.
`default_nettype none

module rgb_quad_to_p010_yuv420
    import rq2p_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    output logic       busy,
    input  wire quad_t quad,
    output logic       done,
    output result_t    result,
    input  wire logic  cfg_we,
    input  wire logic  cfg_index,
    input  wire logic  cfg_data
);

    quad_t             quad_reg, quad_next;
    logic [3:0]        valid_reg, valid_next;
    logic              bgra_order_reg, bgra_order_next;
    logic              use_bt2020_reg, use_bt2020_next;
    logic [LANES-1:0][31:0] pixels;
    logic [LANES-1:0][15:0] lumas;
    rgb8_t [LANES-1:0] chans;
    logic [15:0]       cb_word, cr_word;
    logic              accept;

    // Every cycle can take a transaction.
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Configuration register writes.
    always_comb
    begin
        bgra_order_next = bgra_order_reg;
        use_bt2020_next = use_bt2020_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BGRA_ORDER: bgra_order_next = cfg_data;
                CFG_USE_BT2020: use_bt2020_next = cfg_data;
                default:        ;
            endcase
        end
    end

    // Input capture and valid tracking through the lanes.
    always_comb
    begin
        quad_next  = accept ? quad : quad_reg;
        valid_next = {valid_reg[2:0], accept};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            bgra_order_reg <= 1'b0;
            use_bt2020_reg <= 1'b0;
        end
        else
        begin
            valid_reg      <= valid_next;
            bgra_order_reg <= bgra_order_next;
            use_bt2020_reg <= use_bt2020_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quad_reg <= quad_next;
    end

    assign pixels[0] = quad_reg.pixel_top_left;
    assign pixels[1] = quad_reg.pixel_top_right;
    assign pixels[2] = quad_reg.pixel_bottom_left;
    assign pixels[3] = quad_reg.pixel_bottom_right;

    // One luma lane per pixel of the quad.
    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        rq2p_lane u_lane (
            .clk        (clk),
            .pixel      (pixels[i]),
            .bgra_order (bgra_order_reg),
            .use_bt2020 (use_bt2020_reg),
            .chan       (chans[i]),
            .luma       (lumas[i])
        );
    end

    // Chroma from the channels the lanes split out.
    rq2p_chroma u_chroma (
        .clk        (clk),
        .chans      (chans),
        .use_bt2020 (use_bt2020_reg),
        .cb_word    (cb_word),
        .cr_word    (cr_word)
    );

    // Result transaction.
    assign done                     = valid_reg[3];
    assign result.luma_top_left     = lumas[0];
    assign result.luma_top_right    = lumas[1];
    assign result.luma_bottom_left  = lumas[2];
    assign result.luma_bottom_right = lumas[3];
    assign result.cb_word           = cb_word;
    assign result.cr_word           = cr_word;

endmodule

`default_nettype wire
